FILE: rtl/vfc_pkg.sv
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types, constants and helpers for the view frustum culling block.
// ----------------------------------------------------------------------------
`default_nettype none

package vfc_pkg;

  localparam int unsigned PLANE_COUNT   = 6;
  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef enum logic [2:0] {
    OP_VIEW   = 3'd0,
    OP_PROJ   = 3'd1,
    OP_BUILD  = 3'd2,
    OP_POINT  = 3'd3,
    OP_SPHERE = 3'd4,
    OP_BOX    = 3'd5,
    OP_AABB   = 3'd6
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MM,
    S_PEXT,
    S_LSQ,
    S_SQRT,
    S_DIV,
    S_PT,
    S_TEST,
    S_DONE
  } state_e;

  // plane coefficients a, b, c, d
  typedef logic [3:0][31:0] plane_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] maxv;
    logic signed [65:0] minv;
    maxv = 66'sd2147483647;
    minv = -66'sd2147483648;
    if (v > maxv) return 32'sh7FFF_FFFF;
    if (v < minv) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [32:0] sx33(input logic [31:0] v);
    return $signed({v[31], v});
  endfunction

  function automatic logic signed [32:0] abs33(input logic [31:0] v);
    logic signed [32:0] e;
    e = $signed({v[31], v});
    return v[31] ? -e : e;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/view_frustum_cull.sv
// Sequencing: a matrix row load is taken while idle; a build is paced by the one shared
//   multiplier and the bit-serial square root and divider; a box test runs through up
//   to eight corners in turn, and every multiply-accumulate step uses the shared
//   multiplier.
// Throughput: one item at a time; the input stalls until the item is finished.
// Reset: asynchronous, clears the view and projection matrices and the planes to zero and returns to idle.
// ----------------------------------------------------------------------------
// view_frustum_cull
// Six-plane frustum build from view/projection matrices and shape tests,
// all worked through a single shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module view_frustum_cull #(
  parameter int unsigned FRAC_BITS = vfc_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         op_i,
  input  wire logic [1:0]         row_index_i,
  input  wire logic signed [31:0] arg_x_i,
  input  wire logic signed [31:0] arg_y_i,
  input  wire logic signed [31:0] arg_z_i,
  input  wire logic signed [31:0] arg_u_i,
  input  wire logic signed [31:0] arg_v_i,
  input  wire logic signed [31:0] arg_w_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    inside_res_o
);
  import vfc_pkg::*;

  localparam int unsigned DW  = 32 + FRAC_BITS;
  localparam int unsigned DCW = $clog2(DW);
  localparam logic [2:0] LAST_PLANE = 3'(PLANE_COUNT - 1);

  state_e state_q, state_d;

  logic [31:0] view_q [16];
  logic [31:0] proj_q [16];
  logic [31:0] m_q    [16];
  plane_t      plane_q [PLANE_COUNT];

  logic [2:0]  op_q;
  logic [31:0] a_q   [6];
  logic [31:0] pt_q  [3];
  logic [31:0] ext_q [3];

  logic [5:0]  cnt_q;
  logic [2:0]  p_q;
  logic [1:0]  r_q;
  logic [2:0]  k_q;
  logic [2:0]  c_q;
  logic        ph_q;
  logic [4:0]  sq_cnt_q;
  logic [DCW-1:0] div_cnt_q;

  logic signed [65:0] prod_q;
  logic signed [63:0] acc_q, racc_q, dacc_q;
  logic [63:0] lsq_q, n_q, res_q;
  logic [32:0] len_q;
  logic [32:0] rem_q;
  logic [DW-1:0] quo_q;
  logic        res_bit_q;
  logic        out_valid_q, inside_q;

  logic in_acc;
  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] psh;
  logic [63:0] lsq_n;
  logic [1:0]  kk;
  logic signed [63:0] acc_n, dacc_n, pdist, thr;
  logic        fail;
  logic [63:0] bitv, sq_t;
  logic        sq_ge;
  logic [33:0] dv_t;
  logic        dv_ge;
  logic [DW-1:0] q_fin;
  logic [31:0] pl_word, nx_word;
  logic [31:0] nx_mag;
  logic [2:0]  k_start;

  assign in_acc       = in_valid_i && !in_stall_o;
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

  assign psh     = 64'(prod_q >>> FRAC_BITS);
  assign lsq_n   = lsq_q + prod_q[63:0];
  assign kk      = 2'(k_q - 3'd3);
  assign acc_n   = acc_q + psh;
  assign dacc_n  = dacc_q + psh;
  assign pdist   = dacc_n + 64'($signed(plane_q[p_q][3]));
  assign k_start = (op_q == OP_AABB) ? 3'd0 : 3'd3;

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MM: begin
        mul_a = sx33(view_q[{cnt_q[5:4], cnt_q[1:0]}]);
        mul_b = sx33(proj_q[{cnt_q[1:0], cnt_q[3:2]}]);
      end
      S_LSQ: begin
        mul_a = sx33(plane_q[p_q][r_q]);
        mul_b = sx33(plane_q[p_q][r_q]);
      end
      S_TEST: begin
        if (k_q < 3'd3) begin
          mul_a = sx33(ext_q[k_q[1:0]]);
          mul_b = abs33(plane_q[p_q][k_q[1:0]]);
        end else begin
          mul_a = sx33(plane_q[p_q][kk]);
          mul_b = sx33(pt_q[kk]);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (op_q)
      OP_SPHERE: thr = -64'($signed(a_q[3]));
      OP_AABB:   thr = -racc_q;
      default:   thr = '0;
    endcase
    fail = (pdist < thr);
  end

  // square root step: bit = 4^(31-sq_cnt)
  always_comb begin
    bitv  = 64'd1 << {~sq_cnt_q, 1'b0};
    sq_t  = res_q + bitv;
    sq_ge = (n_q >= sq_t);
  end

  // restoring divider step and next dividend
  always_comb begin
    dv_t    = {rem_q, quo_q[DW-1]};
    dv_ge   = (dv_t >= {1'b0, len_q});
    q_fin   = {quo_q[DW-2:0], dv_ge};
    pl_word = plane_q[p_q][r_q];
    nx_word = plane_q[p_q][2'(r_q + 2'd1)];
    nx_mag  = nx_word[31] ? 32'(-nx_word) : nx_word;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (op_i == OP_BUILD) state_d = S_MM;
          else if (op_i == OP_POINT || op_i == OP_SPHERE || op_i == OP_BOX ||
                   op_i == OP_AABB) state_d = S_PT;
        end
      end
      S_MM:   if (ph_q && cnt_q == 6'd63) state_d = S_PEXT;
      S_PEXT: state_d = S_LSQ;
      S_LSQ: begin
        if (ph_q && r_q == 2'd2) begin
          if (lsq_n != '0) state_d = S_SQRT;
          else if (p_q == LAST_PLANE) state_d = S_IDLE;
          else state_d = S_PEXT;
        end
      end
      S_SQRT: if (sq_cnt_q == 5'd31) state_d = S_DIV;
      S_DIV: begin
        if (div_cnt_q == DCW'(DW - 1) && r_q == 2'd3)
          state_d = (p_q == LAST_PLANE) ? S_IDLE : S_PEXT;
      end
      S_PT:   state_d = S_TEST;
      S_TEST: begin
        if (ph_q && k_q == 3'd5) begin
          if (fail) state_d = S_DONE;
          else if (p_q == LAST_PLANE)
            state_d = (op_q == OP_BOX && c_q != 3'd7) ? S_PT : S_DONE;
        end
      end
      S_DONE: if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // matrices, planes and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        view_q[i] <= '0;
        proj_q[i] <= '0;
      end
      for (int i = 0; i < PLANE_COUNT; i++) plane_q[i] <= '0;
      out_valid_q <= 1'b0;
      inside_q    <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == S_DONE && state_d == S_IDLE) begin
        out_valid_q <= 1'b1;
        inside_q    <= res_bit_q;
      end
      if (in_acc && op_i == OP_VIEW) begin
        view_q[{row_index_i, 2'd0}] <= arg_x_i;
        view_q[{row_index_i, 2'd1}] <= arg_y_i;
        view_q[{row_index_i, 2'd2}] <= arg_z_i;
        view_q[{row_index_i, 2'd3}] <= arg_u_i;
      end
      if (in_acc && op_i == OP_PROJ) begin
        proj_q[{row_index_i, 2'd0}] <= arg_x_i;
        proj_q[{row_index_i, 2'd1}] <= arg_y_i;
        proj_q[{row_index_i, 2'd2}] <= arg_z_i;
        proj_q[{row_index_i, 2'd3}] <= arg_u_i;
      end
      if (state_q == S_PEXT) begin
        for (int r = 0; r < 4; r++) begin
          logic signed [33:0] base, side;
          base = (p_q == 3'd4) ? 34'sd0 : 34'($signed(m_q[{2'(r), 2'd3}]));
          side = 34'($signed(m_q[{2'(r), p_q[2:1]}]));
          if (p_q == 3'd0 || p_q == 3'd3 || p_q == 3'd4)
            plane_q[p_q][r] <= sat32(66'(base + side));
          else
            plane_q[p_q][r] <= sat32(66'(base - side));
        end
      end
      if (state_q == S_DIV && div_cnt_q == DCW'(DW - 1)) begin
        if (pl_word[31]) plane_q[p_q][r_q] <= sat32(-$signed(66'(q_fin)));
        else             plane_q[p_q][r_q] <= sat32($signed(66'(q_fin)));
      end
    end
  end

  // sequencer counters and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      p_q       <= '0;
      r_q       <= '0;
      k_q       <= '0;
      c_q       <= '0;
      ph_q      <= 1'b0;
      sq_cnt_q  <= '0;
      div_cnt_q <= '0;
      res_bit_q <= 1'b0;
      op_q      <= '0;
    end else begin
      prod_q <= mul_a * mul_b;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q  <= op_i;
            a_q[0] <= arg_x_i; a_q[1] <= arg_y_i; a_q[2] <= arg_z_i;
            a_q[3] <= arg_u_i; a_q[4] <= arg_v_i; a_q[5] <= arg_w_i;
            cnt_q <= '0;
            ph_q  <= 1'b0;
            acc_q <= '0;
            p_q   <= '0;
            c_q   <= '0;
          end
        end
        S_MM: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q[1:0] == 2'd3) begin
              m_q[cnt_q[5:2]] <= sat32(66'(acc_n));
              acc_q <= '0;
            end else begin
              acc_q <= acc_n;
            end
          end
        end
        S_PEXT: begin
          r_q   <= '0;
          ph_q  <= 1'b0;
          lsq_q <= '0;
        end
        S_LSQ: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            lsq_q <= lsq_n;
            r_q   <= r_q + 2'd1;
            if (r_q == 2'd2) begin
              n_q      <= lsq_n;
              res_q    <= '0;
              sq_cnt_q <= '0;
              if (lsq_n == '0) p_q <= p_q + 3'd1;
            end
          end
        end
        S_SQRT: begin
          sq_cnt_q <= sq_cnt_q + 5'd1;
          if (sq_ge) begin
            n_q   <= n_q - sq_t;
            res_q <= (res_q >> 1) + bitv;
          end else begin
            res_q <= res_q >> 1;
          end
          if (sq_cnt_q == 5'd31) begin
            len_q     <= sq_ge ? 33'((res_q >> 1) + bitv) : 33'(res_q >> 1);
            r_q       <= '0;
            rem_q     <= '0;
            div_cnt_q <= '0;
            quo_q     <= {(plane_q[p_q][0][31] ? 32'(-plane_q[p_q][0]) : plane_q[p_q][0]),
                          FRAC_BITS'(0)};
          end
        end
        S_DIV: begin
          rem_q     <= dv_ge ? 33'(dv_t - {1'b0, len_q}) : dv_t[32:0];
          quo_q     <= q_fin;
          div_cnt_q <= div_cnt_q + DCW'(1);
          if (div_cnt_q == DCW'(DW - 1)) begin
            div_cnt_q <= '0;
            rem_q     <= '0;
            r_q       <= r_q + 2'd1;
            quo_q     <= {nx_mag, FRAC_BITS'(0)};
            if (r_q == 2'd3) p_q <= p_q + 3'd1;
          end
        end
        S_PT: begin
          for (int i = 0; i < 3; i++) begin
            logic signed [32:0] lo, hi, sm, df;
            lo = sx33(a_q[i]);
            hi = sx33(a_q[i + 3]);
            sm = lo + hi;
            df = hi - lo;
            ext_q[i] <= df[32:1];
            if (op_q == OP_BOX)
              pt_q[i] <= c_q[i] ? sat32(66'(sm)) : sat32(66'(lo - hi));
            else if (op_q == OP_AABB)
              pt_q[i] <= sm[32:1];
            else
              pt_q[i] <= a_q[i];
          end
          p_q    <= '0;
          k_q    <= k_start;
          ph_q   <= 1'b0;
          racc_q <= '0;
          dacc_q <= '0;
        end
        S_TEST: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            k_q <= k_q + 3'd1;
            if (k_q < 3'd3) racc_q <= racc_q + psh;
            else            dacc_q <= dacc_n;
            if (k_q == 3'd5) begin
              racc_q <= '0;
              dacc_q <= '0;
              k_q    <= k_start;
              p_q    <= p_q + 3'd1;
              if (fail) res_bit_q <= 1'b0;
              else if (p_q == LAST_PLANE) begin
                if (op_q == OP_BOX && c_q != 3'd7) c_q <= c_q + 3'd1;
                else res_bit_q <= 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result transfer raised outside completion");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (len_q != '0))
    else $error("normalising by zero length");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MM || state_q == S_TEST || state_q == S_DIV) |-> in_stall_o)
    else $error("input open while busy");
`endif

endmodule

`default_nettype wire
